>>> hdl/lca_pkg.sv
// ============================================================================
// lca_pkg
// Shared types, sizes and codes for the binary-lifting LCA core.
// ============================================================================
package lca_pkg;

    localparam int NODES      = 1024;
    localparam int LEVELS     = 10;
    localparam int NODE_W     = 10;
    localparam int DEPTH_W    = 10;
    localparam int LVL_W      = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int TAB_DEPTH  = NODES * LEVELS;
    localparam int TAB_AW     = $clog2(TAB_DEPTH);
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 16;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    typedef logic [NODE_W-1:0]  node_t;
    typedef logic [DEPTH_W-1:0] depth_t;
    typedef logic [LVL_W-1:0]   lvl_t;
    typedef logic [TAB_AW-1:0]  tab_addr_t;

    typedef enum logic {
        KIND_INSERT,
        KIND_QUERY
    } kind_t;

    typedef struct packed {
        kind_t kind;
        node_t child;
        node_t parent;
        node_t qa;
        node_t qb;
    } item_t;

    typedef struct packed {
        logic  valid;
        item_t item;
    } q_head_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INS_WDEP,
        ST_INS_RD,
        ST_INS_WR,
        ST_Q_CMP,
        ST_Q_LIFT,
        ST_Q_LIFT_WT,
        ST_Q_EQ,
        ST_Q_UP,
        ST_Q_UP_WT,
        ST_Q_FIN,
        ST_Q_FIN_WT,
        ST_Q_OUT
    } state_t;

    // flat address of level j in the row of node n
    function automatic tab_addr_t row_addr(node_t n, lvl_t j);
        return TAB_AW'(int'(n) * LEVELS + int'(j));
    endfunction

endpackage

>>> hdl/lca_binary_lifting_core.sv
// ============================================================================
// lca_binary_lifting_core
// Lowest common ancestor over a tree held as binary-lifting tables.
// ============================================================================
//
// Channel  Dir  Handshake          Payload
// -------  ---  -----------------  ------------------------------------------
// s_*      in   s_tvalid/s_tready  tuser[0] op (0 insert, 1 query);
//                                  tdata child, parent, query_a, query_b
// m_*      out  m_tvalid/m_tready  tdata ancestor (one transfer per query)
//
// Insert: the back end writes level 0 of the child row and reads the parent
// depth, writes the child depth, then does one dependent ancestor-table
// read and write per level above zero. Query: depth read and compare, a lift
// sweep from the top level down with an extra table read per set gap bit,
// one equality check, then the result load if the lifted nodes match, else
// a second sweep and a parent read first (dual read port on the table).
// Inserts of the root are absorbed by the front end and take no back-end
// time. Reset leaves no clearing pass: the root row and depth read as zero
// by address decode, other rows are defined once inserted. A two-entry
// queue lets input transfers continue while the back end works, and the
// result register lets the next command start while a result waits on
// m_tready.
//
module lca_binary_lifting_core
    import lca_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // child_node, parent_node, query_a, query_b
    input  logic [0:0]            s_tuser,   // op
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata    // ancestor, zero padded
);

    q_head_t q_head;
    logic    q_pop;

    // accept and decode, buffer commands
    lca_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_head   (q_head),
        .q_pop    (q_pop)
    );

    // table walk engine and result register
    lca_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_head   (q_head),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

>>> hdl/lca_front.sv
// ============================================================================
// lca_front
// Input acceptance, op decode and a two-entry command queue.
// ============================================================================
module lca_front
    import lca_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [IN_DATA_W-1:0] s_tdata,
    input  logic [0:0]           s_tuser,
    output q_head_t              q_head,
    input  logic                 q_pop
);

    item_t      entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    item_t      in_item;
    logic       push;
    logic       xfer;

    // decode; an insert of the root is a no-op and is dropped here
    always_comb
    begin
        in_item.kind   = (s_tuser[0] == OP_QUERY) ? KIND_QUERY : KIND_INSERT;
        in_item.child  = s_tdata[NODE_W-1:0];
        in_item.parent = s_tdata[2*NODE_W-1:NODE_W];
        in_item.qa     = s_tdata[3*NODE_W-1:2*NODE_W];
        in_item.qb     = s_tdata[4*NODE_W-1:3*NODE_W];
    end

    assign s_tready = (count_reg != 2'd2);
    assign xfer     = s_tvalid && s_tready;
    assign push     = xfer && ((s_tuser[0] == OP_QUERY) || (in_item.child != '0));

    assign q_head.valid = (count_reg != 2'd0);
    assign q_head.item  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ q_pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, q_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

>>> hdl/lca_back.sv
// ============================================================================
// lca_back
// Sequencer over the depth and ancestor memories, with the result register.
// ============================================================================
module lca_back
    import lca_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  q_head_t               q_head,
    output logic                  q_pop,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata
);

    // storage; the root row is never written and reads as zero
    depth_t depth_mem [NODES];
    node_t  tab_mem   [TAB_DEPTH];

    state_t state_reg, state_next;
    lvl_t   lvl_reg, lvl_next;
    node_t  a_reg, a_next;
    node_t  b_reg, b_next;
    node_t  c_reg, c_next;
    depth_t gap_reg, gap_next;
    logic   out_valid_reg, out_valid_next;
    node_t  out_data_reg, out_data_next;

    // memory ports
    node_t  dep_ra, dep_rb, dep_wnode;
    depth_t dep_wdata;
    logic   dep_we;
    node_t  tab_ra_node, tab_rb_node, tab_wnode;
    lvl_t   tab_ra_lvl, tab_rb_lvl, tab_wlvl;
    node_t  tab_wdata;
    logic   tab_we;

    depth_t dep_a_q, dep_b_q;
    node_t  tab_a_q, tab_b_q;
    logic   dz_a_q, dz_b_q, tz_a_q, tz_b_q;

    depth_t dep_a, dep_b;
    node_t  tab_a, tab_b;
    logic   gap_bit;
    logic   out_free;

    assign dep_a = dz_a_q ? '0 : dep_a_q;
    assign dep_b = dz_b_q ? '0 : dep_b_q;
    assign tab_a = tz_a_q ? '0 : tab_a_q;
    assign tab_b = tz_b_q ? '0 : tab_b_q;

    assign gap_bit  = (gap_reg >> lvl_reg) != '0 ? ((gap_reg >> lvl_reg) & depth_t'(1)) != '0
                                                 : 1'b0;
    assign out_free = !out_valid_reg || m_tready;

    // next state and datapath registers
    always_comb
    begin
        state_next     = state_reg;
        lvl_next       = lvl_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        c_next         = c_reg;
        gap_next       = gap_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (q_head.valid)
                begin
                    c_next = q_head.item.child;
                    b_next = q_head.item.qb;
                    if (q_head.item.kind == KIND_INSERT)
                    begin
                        a_next     = q_head.item.parent;
                        state_next = ST_INS_WDEP;
                    end
                    else
                    begin
                        a_next     = q_head.item.qa;
                        state_next = ST_Q_CMP;
                    end
                end
            end
            ST_INS_WDEP:
            begin
                lvl_next   = lvl_t'(1);
                state_next = (LEVELS == 1) ? ST_IDLE : ST_INS_RD;
            end
            ST_INS_RD:
            begin
                state_next = ST_INS_WR;
            end
            ST_INS_WR:
            begin
                a_next = tab_a;
                if (lvl_reg == lvl_t'(LEVELS - 1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    lvl_next   = lvl_reg + lvl_t'(1);
                    state_next = ST_INS_RD;
                end
            end
            ST_Q_CMP:
            begin
                if (dep_a < dep_b)
                begin
                    a_next   = b_reg;
                    b_next   = a_reg;
                    gap_next = dep_b - dep_a;
                end
                else
                begin
                    gap_next = dep_a - dep_b;
                end
                lvl_next   = lvl_t'(LEVELS - 1);
                state_next = ST_Q_LIFT;
            end
            ST_Q_LIFT:
            begin
                if (gap_bit)
                begin
                    state_next = ST_Q_LIFT_WT;
                end
                else if (lvl_reg == '0)
                begin
                    state_next = ST_Q_EQ;
                end
                else
                begin
                    lvl_next = lvl_reg - lvl_t'(1);
                end
            end
            ST_Q_LIFT_WT:
            begin
                a_next = tab_a;
                if (lvl_reg == '0)
                begin
                    state_next = ST_Q_EQ;
                end
                else
                begin
                    lvl_next   = lvl_reg - lvl_t'(1);
                    state_next = ST_Q_LIFT;
                end
            end
            ST_Q_EQ:
            begin
                lvl_next   = lvl_t'(LEVELS - 1);
                state_next = (a_reg == b_reg) ? ST_Q_OUT : ST_Q_UP;
            end
            ST_Q_UP:
            begin
                state_next = ST_Q_UP_WT;
            end
            ST_Q_UP_WT:
            begin
                if (tab_a != tab_b)
                begin
                    a_next = tab_a;
                    b_next = tab_b;
                end
                if (lvl_reg == '0)
                begin
                    state_next = ST_Q_FIN;
                end
                else
                begin
                    lvl_next   = lvl_reg - lvl_t'(1);
                    state_next = ST_Q_UP;
                end
            end
            ST_Q_FIN:
            begin
                state_next = ST_Q_FIN_WT;
            end
            ST_Q_FIN_WT:
            begin
                a_next     = tab_a;
                state_next = ST_Q_OUT;
            end
            ST_Q_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = a_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // memory controls
    always_comb
    begin
        q_pop       = 1'b0;
        dep_ra      = a_reg;
        dep_rb      = b_reg;
        dep_we      = 1'b0;
        dep_wnode   = c_reg;
        dep_wdata   = dep_a + depth_t'(1);
        tab_ra_node = a_reg;
        tab_ra_lvl  = lvl_reg;
        tab_rb_node = b_reg;
        tab_rb_lvl  = lvl_reg;
        tab_we      = 1'b0;
        tab_wnode   = c_reg;
        tab_wlvl    = lvl_reg;
        tab_wdata   = tab_a;
        case (state_reg)
            ST_IDLE:
            begin
                q_pop  = q_head.valid;
                dep_rb = q_head.item.qb;
                if (q_head.item.kind == KIND_INSERT)
                begin
                    dep_ra    = q_head.item.parent;
                    tab_we    = q_head.valid;
                    tab_wnode = q_head.item.child;
                    tab_wlvl  = '0;
                    tab_wdata = q_head.item.parent;
                end
                else
                begin
                    dep_ra = q_head.item.qa;
                end
            end
            ST_INS_WDEP:
            begin
                dep_we = 1'b1;
            end
            ST_INS_RD:
            begin
                tab_ra_lvl = lvl_reg - lvl_t'(1);
            end
            ST_INS_WR:
            begin
                tab_we = 1'b1;
            end
            ST_Q_FIN:
            begin
                tab_ra_lvl = '0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (dep_we)
        begin
            depth_mem[dep_wnode] <= dep_wdata;
        end
        if (tab_we)
        begin
            tab_mem[row_addr(tab_wnode, tab_wlvl)] <= tab_wdata;
        end
        dep_a_q <= depth_mem[dep_ra];
        dep_b_q <= depth_mem[dep_rb];
        tab_a_q <= tab_mem[row_addr(tab_ra_node, tab_ra_lvl)];
        tab_b_q <= tab_mem[row_addr(tab_rb_node, tab_rb_lvl)];
        dz_a_q  <= (dep_ra == '0);
        dz_b_q  <= (dep_rb == '0);
        tz_a_q  <= (tab_ra_node == '0);
        tz_b_q  <= (tab_rb_node == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lvl_reg      <= lvl_next;
        a_reg        <= a_next;
        b_reg        <= b_next;
        c_reg        <= c_next;
        gap_reg      <= gap_next;
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_DATA_W - NODE_W){1'b0}}, out_data_reg};

    // queue is drained only between commands
    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (state_reg == ST_IDLE))
        else $error("queue pop while a command is in flight");

    // the root row must stay untouched
    a_root_fixed: assert property (@(posedge clk) disable iff (!rst_n)
        (tab_we || dep_we) |-> ((tab_we && tab_wnode != '0) || (dep_we && dep_wnode != '0)))
        else $error("write to the root entry");

    // a finished query reaches the result register
    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_Q_OUT && out_free) |=> (out_valid_reg && state_reg == ST_IDLE))
        else $error("query result not loaded");

    // sweep level stays inside the table
    a_lvl_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE && state_reg != ST_INS_WDEP && state_reg != ST_Q_CMP)
        |-> (lvl_reg <= lvl_t'(LEVELS - 1)))
        else $error("level counter out of range");

endmodule
